// ----- hdl/dcl_pkg.sv -----
package dcl_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COMMAND_TYPE   = 3'd0,
        CFG_PAYLOAD_LENGTH = 3'd1,
        CFG_INVALID_LIMIT  = 3'd2,
        CFG_DUTY_LIMIT     = 3'd3,
        CFG_ENABLE_MASK    = 3'd4
    } cfg_index_t;

    // Register reset values
    localparam logic [7:0]  RST_COMMAND_TYPE   = 8'd0;
    localparam logic [7:0]  RST_PAYLOAD_LENGTH = 8'd13;
    localparam logic [15:0] RST_INVALID_LIMIT  = 16'd3;
    localparam logic [14:0] RST_DUTY_LIMIT     = 15'd1000;
    localparam logic [7:0]  RST_ENABLE_MASK    = 8'd1;

    // Saturation value of the invalid counter
    localparam logic [15:0] INVALID_MAX = 16'hFFFF;

    // Symmetric clamp of a signed duty to [-lim, +lim]
    function automatic logic signed [15:0] clamp_duty(
        input logic signed [15:0] d,
        input logic        [14:0] lim
    );
        logic signed [16:0] d_ext;
        logic signed [16:0] pos_lim;
        logic signed [16:0] neg_lim;
        logic signed [15:0] res;
        d_ext   = {d[15], d};
        pos_lim = {2'b00, lim};
        neg_lim = -pos_lim;
        if (d_ext > pos_lim)
        begin
            res = pos_lim[15:0];
        end
        else if (d_ext < neg_lim)
        begin
            res = neg_lim[15:0];
        end
        else
        begin
            res = d;
        end
        return res;
    endfunction

endpackage

// ----- hdl/drive_command_link_watchdog.sv -----
// Channel   | Handshake            | Payload
// ----------+----------------------+-----------------------------------------------
// input     | in_valid / in_stall  | kind, now_ms, header_ok, msg_type, ...
// output    | out_valid / out_stall| accepted, link_fresh, ..., expiry_time
// config    | cfg_write            | cfg_index, cfg_data (no read-back)
//
// Two register stages: an input register, then the check / state update and
// the report logic feeding the result register. One item per cycle sustained
// while out_stall is low; the result register is the only hold point.
// rst_n clears control state, the stored command and loads register defaults.
// A stalled result holds both registers and raises in_stall.
module drive_command_link_watchdog
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write,
    input  logic [dcl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dcl_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [31:0]                       now_ms,
    input  logic                              header_ok,
    input  logic [7:0]                        msg_type,
    input  logic [7:0]                        pay_len,
    input  logic [15:0]                       sequence_req,
    input  logic [7:0]                        flags_byte,
    input  logic signed [15:0]                left_duty_in,
    input  logic signed [15:0]                right_duty_in,
    input  logic [31:0]                       timeout_in,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              accepted,
    output logic                              link_fresh,
    output logic                              command_valid,
    output logic [31:0]                       cmd_age,
    output logic [15:0]                       last_seq_out,
    output logic [15:0]                       invalid_count_out,
    output logic                              left_enabled,
    output logic signed [15:0]                left_duty_out,
    output logic                              right_enabled,
    output logic signed [15:0]                right_duty_out,
    output logic [31:0]                       expiry_time
);

    // Configuration registers
    logic [7:0]  command_type_reg;
    logic [7:0]  payload_length_reg;
    logic [15:0] invalid_limit_reg;
    logic [14:0] duty_limit_reg;
    logic [7:0]  enable_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_type_reg   <= dcl_pkg::RST_COMMAND_TYPE;
            payload_length_reg <= dcl_pkg::RST_PAYLOAD_LENGTH;
            invalid_limit_reg  <= dcl_pkg::RST_INVALID_LIMIT;
            duty_limit_reg     <= dcl_pkg::RST_DUTY_LIMIT;
            enable_mask_reg    <= dcl_pkg::RST_ENABLE_MASK;
        end
        else if (cfg_write)
        begin
            unique case (dcl_pkg::cfg_index_t'(cfg_index))
                dcl_pkg::CFG_COMMAND_TYPE:   command_type_reg   <= cfg_data[7:0];
                dcl_pkg::CFG_PAYLOAD_LENGTH: payload_length_reg <= cfg_data[7:0];
                dcl_pkg::CFG_INVALID_LIMIT:  invalid_limit_reg  <= cfg_data;
                dcl_pkg::CFG_DUTY_LIMIT:     duty_limit_reg     <= cfg_data[14:0];
                dcl_pkg::CFG_ENABLE_MASK:    enable_mask_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic fire;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= in_valid;
            out_valid_reg <= in_valid_reg;
        end
    end

    // Input register
    logic               kind_reg;
    logic [31:0]        now_reg;
    logic               header_ok_reg;
    logic [7:0]         msg_type_reg;
    logic [7:0]         pay_len_reg;
    logic [15:0]        sequence_reg;
    logic [7:0]         flags_reg;
    logic signed [15:0] left_in_reg;
    logic signed [15:0] right_in_reg;
    logic [31:0]        timeout_in_reg;

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            kind_reg         <= kind;
            now_reg          <= now_ms;
            header_ok_reg    <= header_ok;
            msg_type_reg     <= msg_type;
            pay_len_reg      <= pay_len;
            sequence_reg     <= sequence_req;
            flags_reg        <= flags_byte;
            left_in_reg      <= left_duty_in;
            right_in_reg     <= right_duty_in;
            timeout_in_reg   <= timeout_in;
        end
    end

    // Stored command state
    logic               stored_enable_reg, stored_enable_next;
    logic signed [15:0] stored_left_reg, stored_left_next;
    logic signed [15:0] stored_right_reg, stored_right_next;
    logic [31:0]        stored_timeout_reg, stored_timeout_next;
    logic [31:0]        arrival_reg, arrival_next;
    logic [15:0]        last_seq_reg, last_seq_next;
    logic               have_command_reg, have_command_next;
    logic [15:0]        invalid_count_reg, invalid_count_next;

    // Packet check and state update
    logic pkt_good;
    logic pkt_accept;

    always_comb
    begin
        pkt_good = header_ok_reg
                && (msg_type_reg == command_type_reg)
                && (pay_len_reg == payload_length_reg)
                && (timeout_in_reg != 32'd0)
                && !(have_command_reg && (sequence_reg == last_seq_reg));
        pkt_accept = !kind_reg && pkt_good;

        stored_enable_next  = stored_enable_reg;
        stored_left_next    = stored_left_reg;
        stored_right_next   = stored_right_reg;
        stored_timeout_next = stored_timeout_reg;
        arrival_next        = arrival_reg;
        last_seq_next       = last_seq_reg;
        have_command_next   = have_command_reg;
        invalid_count_next  = invalid_count_reg;

        if (pkt_accept)
        begin
            stored_enable_next  = (flags_reg & enable_mask_reg) != 8'd0;
            stored_left_next    = dcl_pkg::clamp_duty(left_in_reg, duty_limit_reg);
            stored_right_next   = dcl_pkg::clamp_duty(right_in_reg, duty_limit_reg);
            stored_timeout_next = timeout_in_reg;
            arrival_next        = now_reg;
            last_seq_next       = sequence_reg;
            have_command_next   = 1'b1;
            invalid_count_next  = 16'd0;
        end
        else if (!kind_reg && (invalid_count_reg != dcl_pkg::INVALID_MAX))
        begin
            invalid_count_next = invalid_count_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_enable_reg  <= 1'b0;
            stored_left_reg    <= '0;
            stored_right_reg   <= '0;
            stored_timeout_reg <= '0;
            arrival_reg        <= '0;
            last_seq_reg       <= '0;
            have_command_reg   <= 1'b0;
            invalid_count_reg  <= '0;
        end
        else if (fire)
        begin
            stored_enable_reg  <= stored_enable_next;
            stored_left_reg    <= stored_left_next;
            stored_right_reg   <= stored_right_next;
            stored_timeout_reg <= stored_timeout_next;
            arrival_reg        <= arrival_next;
            last_seq_reg       <= last_seq_next;
            have_command_reg   <= have_command_next;
            invalid_count_reg  <= invalid_count_next;
        end
    end

    // Report on the updated state
    logic [31:0]        age_raw;
    logic [31:0]        age_val;
    logic               fresh;
    logic               drive_on;
    logic signed [15:0] left_duty_val;
    logic signed [15:0] right_duty_val;

    always_comb
    begin
        age_raw = (now_reg >= arrival_next) ? (now_reg - arrival_next) : 32'd0;
        age_val = have_command_next ? age_raw : 32'd0;
        fresh   = have_command_next
               && (invalid_count_next < invalid_limit_reg)
               && (age_raw <= stored_timeout_next);
        drive_on = fresh && stored_enable_next;
        left_duty_val  = drive_on ? dcl_pkg::clamp_duty(stored_left_next, duty_limit_reg)
                                  : 16'sd0;
        right_duty_val = drive_on ? dcl_pkg::clamp_duty(stored_right_next, duty_limit_reg)
                                  : 16'sd0;
    end

    // Result register
    logic               accepted_reg;
    logic               healthy_reg;
    logic               command_valid_reg;
    logic [31:0]        age_reg;
    logic [15:0]        last_seq_out_reg;
    logic [15:0]        invalid_out_reg;
    logic signed [15:0] left_duty_reg;
    logic signed [15:0] right_duty_reg;
    logic [31:0]        expires_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            accepted_reg      <= pkt_accept;
            healthy_reg       <= fresh;
            command_valid_reg <= have_command_next;
            age_reg           <= age_val;
            last_seq_out_reg  <= last_seq_next;
            invalid_out_reg   <= invalid_count_next;
            left_duty_reg     <= left_duty_val;
            right_duty_reg    <= right_duty_val;
            expires_reg       <= drive_on ? (arrival_next + stored_timeout_next) : 32'd0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign accepted          = accepted_reg;
    assign link_fresh        = healthy_reg;
    assign command_valid     = command_valid_reg;
    assign cmd_age           = age_reg;
    assign last_seq_out      = last_seq_out_reg;
    assign invalid_count_out = invalid_out_reg;
    assign left_enabled      = left_duty_reg != 16'sd0;
    assign left_duty_out     = left_duty_reg;
    assign right_enabled     = right_duty_reg != 16'sd0;
    assign right_duty_out    = right_duty_reg;
    assign expiry_time       = expires_reg;

endmodule
